// ===== hw/rtl/cfpd_pkg.sv =====
// ----------------------------------------------------------------------------
// cfpd_pkg
// Shared constants, codes and the CRC-16/CCITT byte update for the framed
// packet decoder.
// ----------------------------------------------------------------------------
package cfpd_pkg;

    localparam int PAYLOAD_DEPTH = 64;
    localparam int PL_AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    // result event codes
    localparam logic [2:0] EV_ACCEPT  = 3'd0;
    localparam logic [2:0] EV_BAD_LEN = 3'd1;
    localparam logic [2:0] EV_BAD_CRC = 3'd2;
    localparam logic [2:0] EV_BAD_END = 3'd3;
    localparam logic [2:0] EV_BAD_TAIL = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_HEADER  = 3'd0;
    localparam logic [2:0] CFG_ENDCODE = 3'd1;
    localparam logic [2:0] CFG_TAIL    = 3'd2;
    localparam logic [2:0] CFG_MAX_LEN = 3'd3;
    localparam logic [2:0] CFG_SEED    = 3'd4;

    // MSB-first CRC update over one byte
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc,
                                               input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/cfpd_ifs.sv =====
// ----------------------------------------------------------------------------
// cfpd channel interfaces
// Valid/ready channels for received bytes and decoder results.
// ----------------------------------------------------------------------------
interface cfpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfpd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  payload_byte;
    logic [5:0]  byte_index;
    logic [15:0] frame_type;
    logic [15:0] frame_length;
    logic        last;
    logic [31:0] accepted_count;
    logic [31:0] rejected_count;
    logic [31:0] bad_crc_count;
    logic [31:0] len_err_count;

    modport source (output valid, output event_res, output payload_byte,
                    output byte_index, output frame_type, output frame_length,
                    output last, output accepted_count, output rejected_count,
                    output bad_crc_count, output len_err_count, input ready);
    modport sink   (input valid, input event_res, input payload_byte,
                    input byte_index, input frame_type, input frame_length,
                    input last, input accepted_count, input rejected_count,
                    input bad_crc_count, input len_err_count, output ready);
endinterface

// ===== hw/rtl/crc_framed_packet_decoder_core.sv =====
// ----------------------------------------------------------------------------
// crc_framed_packet_decoder_core
// Hunts for framed packets in a byte stream, checks length, endcode, CRC and
// tail, and replays the buffered payload of each good frame.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  rx      | in  | valid/ready         | rx_byte
//  res     | out | valid/ready         | event, payload byte, index, frame
//          |     |                     | fields, last, four counters
//  cfg     | in  | cfg_we, no wait     | cfg_index, cfg_data
//
// One request per cycle while parsing; a byte is taken only while the output
// register is empty or its result leaves in the same cycle. After a good tail
// the payload is read back from the buffer RAM byte by byte (read, then load
// output); input is held off until the last payload byte has been loaded.
// Reset is asynchronous, active low; the buffer RAM needs no clearing.
// ----------------------------------------------------------------------------
module crc_framed_packet_decoder_core
    import cfpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    cfpd_in_if.sink     rx,
    cfpd_out_if.source  res,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [3:0] PH_HUNT    = 4'd0;
    localparam logic [3:0] PH_TYPE    = 4'd1;
    localparam logic [3:0] PH_LEN     = 4'd2;
    localparam logic [3:0] PH_DATA    = 4'd3;
    localparam logic [3:0] PH_END     = 4'd4;
    localparam logic [3:0] PH_CRC     = 4'd5;
    localparam logic [3:0] PH_TAIL    = 4'd6;
    localparam logic [3:0] PH_EMIT_RD = 4'd7;
    localparam logic [3:0] PH_EMIT_WR = 4'd8;

    localparam logic [6:0] DEPTH7 = 7'(PAYLOAD_DEPTH);

    logic [3:0]  phase_reg, phase_next;
    logic [6:0]  pos_reg, pos_next;
    logic [15:0] type_reg, type_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;
    logic [6:0]  emit_idx_reg, emit_idx_next;
    logic [31:0] acc_cnt_reg, acc_cnt_next;
    logic [31:0] rej_cnt_reg, rej_cnt_next;
    logic [31:0] crc_cnt_reg, crc_cnt_next;
    logic [31:0] len_cnt_reg, len_cnt_next;

    logic [7:0]  header_reg, endcode_reg, tail_reg;
    logic [6:0]  max_len_reg;
    logic [15:0] seed_reg;

    logic        out_valid_reg, out_valid_next;
    logic        out_load;
    logic [2:0]  out_event_reg, out_event_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic [5:0]  out_idx_reg, out_idx_next;
    logic [15:0] out_type_reg;
    logic [15:0] out_len_reg, out_len_next;
    logic        out_last_reg, out_last_next;
    logic [31:0] out_acc_reg, out_rej_reg, out_crc_reg, out_lcnt_reg;

    logic              slot_free, in_ok, emitting;
    logic [7:0]        b;
    logic [6:0]        limit;
    logic [15:0]       len_full;
    logic [6:0]        pos_inc;
    logic              ram_we, ram_re;
    logic [PL_AW-1:0]  ram_waddr, ram_raddr;
    logic [7:0]        ram_rdata;

    cfpd_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_DEPTH)
    ) u_payload_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (b),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign emitting  = (phase_reg == PH_EMIT_RD) || (phase_reg == PH_EMIT_WR);
    assign slot_free = !out_valid_reg || res.ready;
    assign rx.ready  = slot_free && !emitting;
    assign in_ok     = rx.valid && rx.ready;
    assign b         = rx.rx_byte;
    assign limit     = (max_len_reg < DEPTH7) ? max_len_reg : DEPTH7;
    assign len_full  = {b, len_reg[7:0]};
    assign pos_inc   = pos_reg + 7'd1;
    assign ram_waddr = pos_reg[PL_AW-1:0];
    assign ram_raddr = emit_idx_reg[PL_AW-1:0];

    always_comb
    begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        type_next      = type_reg;
        len_next       = len_reg;
        crc_next       = crc_reg;
        crc_lo_next    = crc_lo_reg;
        emit_idx_next  = emit_idx_reg;
        acc_cnt_next   = acc_cnt_reg;
        rej_cnt_next   = rej_cnt_reg;
        crc_cnt_next   = crc_cnt_reg;
        len_cnt_next   = len_cnt_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        out_load       = 1'b0;
        out_event_next = EV_ACCEPT;
        out_byte_next  = 8'h00;
        out_idx_next   = 6'd0;
        out_len_next   = len_reg;
        out_last_next  = 1'b1;

        case (phase_reg)
            PH_HUNT:
            begin
                if (in_ok && b == header_reg)
                begin
                    crc_next   = seed_reg;
                    pos_next   = 7'd0;
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                if (in_ok)
                begin
                    crc_next = crc16_feed(crc_reg, b);
                    if (pos_reg == 7'd0)
                    begin
                        type_next = {8'h00, b};
                        pos_next  = 7'd1;
                    end
                    else
                    begin
                        type_next  = {b, type_reg[7:0]};
                        pos_next   = 7'd0;
                        phase_next = PH_LEN;
                    end
                end
            end
            PH_LEN:
            begin
                if (in_ok)
                begin
                    crc_next = crc16_feed(crc_reg, b);
                    if (pos_reg == 7'd0)
                    begin
                        len_next = {8'h00, b};
                        pos_next = 7'd1;
                    end
                    else
                    begin
                        len_next = len_full;
                        pos_next = 7'd0;
                        if (len_full == 16'd0 || len_full > {9'd0, limit})
                        begin
                            len_cnt_next   = len_cnt_reg + 32'd1;
                            phase_next     = PH_HUNT;
                            out_load       = 1'b1;
                            out_event_next = EV_BAD_LEN;
                            out_len_next   = len_full;
                        end
                        else
                            phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                if (in_ok)
                begin
                    ram_we   = 1'b1;
                    crc_next = crc16_feed(crc_reg, b);
                    if ({9'd0, pos_inc} >= len_reg)
                    begin
                        pos_next   = 7'd0;
                        phase_next = PH_END;
                    end
                    else
                        pos_next = pos_inc;
                end
            end
            PH_END:
            begin
                if (in_ok)
                begin
                    if (b == endcode_reg)
                    begin
                        crc_next   = crc16_feed(crc_reg, b);
                        pos_next   = 7'd0;
                        phase_next = PH_CRC;
                    end
                    else
                    begin
                        phase_next     = PH_HUNT;
                        out_load       = 1'b1;
                        out_event_next = EV_BAD_END;
                    end
                end
            end
            PH_CRC:
            begin
                if (in_ok)
                begin
                    if (pos_reg == 7'd0)
                    begin
                        crc_lo_next = b;
                        pos_next    = 7'd1;
                    end
                    else
                    begin
                        pos_next = 7'd0;
                        if (crc_reg == {b, crc_lo_reg})
                            phase_next = PH_TAIL;
                        else
                        begin
                            crc_cnt_next   = crc_cnt_reg + 32'd1;
                            rej_cnt_next   = rej_cnt_reg + 32'd1;
                            phase_next     = PH_HUNT;
                            out_load       = 1'b1;
                            out_event_next = EV_BAD_CRC;
                        end
                    end
                end
            end
            PH_TAIL:
            begin
                if (in_ok)
                begin
                    pos_next = 7'd0;
                    if (b != tail_reg)
                    begin
                        phase_next     = PH_HUNT;
                        out_load       = 1'b1;
                        out_event_next = EV_BAD_TAIL;
                    end
                    else
                    begin
                        acc_cnt_next  = acc_cnt_reg + 32'd1;
                        emit_idx_next = 7'd0;
                        phase_next    = PH_EMIT_RD;
                    end
                end
            end
            PH_EMIT_RD:
            begin
                ram_re     = 1'b1;
                phase_next = PH_EMIT_WR;
            end
            PH_EMIT_WR:
            begin
                // hold the read data until the output slot frees up
                if (slot_free)
                begin
                    out_load       = 1'b1;
                    out_event_next = EV_ACCEPT;
                    out_byte_next  = ram_rdata;
                    out_idx_next   = emit_idx_reg[5:0];
                    out_last_next  = (emit_idx_reg + 7'd1) == len_reg[6:0];
                    if (out_last_next)
                        phase_next = PH_HUNT;
                    else
                    begin
                        emit_idx_next = emit_idx_reg + 7'd1;
                        phase_next    = PH_EMIT_RD;
                    end
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
                pos_next   = 7'd0;
            end
        endcase

        out_valid_next = out_load || (out_valid_reg && !res.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            pos_reg       <= 7'd0;
            type_reg      <= 16'd0;
            len_reg       <= 16'd0;
            crc_reg       <= 16'd0;
            crc_lo_reg    <= 8'd0;
            emit_idx_reg  <= 7'd0;
            acc_cnt_reg   <= 32'd0;
            rej_cnt_reg   <= 32'd0;
            crc_cnt_reg   <= 32'd0;
            len_cnt_reg   <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            type_reg      <= type_next;
            len_reg       <= len_next;
            crc_reg       <= crc_next;
            crc_lo_reg    <= crc_lo_next;
            emit_idx_reg  <= emit_idx_next;
            acc_cnt_reg   <= acc_cnt_next;
            rej_cnt_reg   <= rej_cnt_next;
            crc_cnt_reg   <= crc_cnt_next;
            len_cnt_reg   <= len_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg  <= 8'hAA;
            endcode_reg <= 8'h55;
            tail_reg    <= 8'hCC;
            max_len_reg <= 7'd64;
            seed_reg    <= 16'hFFFF;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HEADER:  header_reg  <= cfg_data[7:0];
                CFG_ENDCODE: endcode_reg <= cfg_data[7:0];
                CFG_TAIL:    tail_reg    <= cfg_data[7:0];
                CFG_MAX_LEN: max_len_reg <= cfg_data[6:0];
                CFG_SEED:    seed_reg    <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_event_reg <= out_event_next;
            out_byte_reg  <= out_byte_next;
            out_idx_reg   <= out_idx_next;
            out_type_reg  <= type_reg;
            out_len_reg   <= out_len_next;
            out_last_reg  <= out_last_next;
            out_acc_reg   <= acc_cnt_next;
            out_rej_reg   <= rej_cnt_next;
            out_crc_reg   <= crc_cnt_next;
            out_lcnt_reg  <= len_cnt_next;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.event_res      = out_event_reg;
    assign res.payload_byte   = out_byte_reg;
    assign res.byte_index     = out_idx_reg;
    assign res.frame_type     = out_type_reg;
    assign res.frame_length   = out_len_reg;
    assign res.last           = out_last_reg;
    assign res.accepted_count = out_acc_reg;
    assign res.rejected_count = out_rej_reg;
    assign res.bad_crc_count  = out_crc_reg;
    assign res.len_err_count  = out_lcnt_reg;

    // no byte is taken while the buffer is being replayed
    a_no_input_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
        rx.ready |-> !emitting)
        else $error("input ready during payload replay");

    a_replay_index_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_EMIT_WR) |-> (emit_idx_reg < len_reg[6:0]))
        else $error("replay index beyond frame length");

    a_data_length_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (len_reg != 16'd0 && len_reg <= {9'd0, DEPTH7}))
        else $error("payload phase with unchecked length");

    a_reject_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_event_reg != EV_ACCEPT)
            |-> (out_byte_reg == 8'h00 && out_idx_reg == 6'd0 && out_last_reg))
        else $error("reject result with payload fields set");

    a_replay_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_event_reg == EV_ACCEPT && !out_last_reg) |-> emitting)
        else $error("replay stopped before last byte");

endmodule

// ===== hw/rtl/cfpd_ram.sv =====
// ----------------------------------------------------------------------------
// cfpd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cfpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Byte-stream test of the framed packet decoder. Well-formed frames with random
// content are mixed with bad length, endcode, CRC and tail faults, truncated
// frames and noise. The bench tracks the decoder's parse state, CRC, payload
// and counters on its side and checks every result against its own prediction.
// It also sweeps the decoder registers and runs with random gaps and output
// back-pressure.
// ----------------------------------------------------------------------------
module tb;
    import cfpd_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 40;

    typedef enum logic [2:0] {
        SEEK_HEADER,
        GET_TYPE,
        GET_LENGTH,
        GET_DATA,
        GET_ENDCODE,
        GET_CRC,
        GET_TAIL
    } parse_phase_t;

    typedef enum int {
        FAULT_NONE,
        FAULT_LENGTH,
        FAULT_ENDCODE,
        FAULT_CRC,
        FAULT_TAIL,
        FAULT_TRUNCATED
    } frame_fault_t;

    typedef struct {
        logic [2:0]  ev;
        logic [7:0]  data;
        logic [5:0]  index;
        logic [15:0] ftype;
        logic [15:0] flen;
        logic        last;
        logic [31:0] n_acc;
        logic [31:0] n_rej;
        logic [31:0] n_crc;
        logic [31:0] n_len;
    } decode_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    cfpd_in_if  rx_ch();
    cfpd_out_if res_ch();

    crc_framed_packet_decoder_core u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register copies, reset values
    logic [7:0]  c_header   = 8'hAA;
    logic [7:0]  c_endcode  = 8'h55;
    logic [7:0]  c_tail     = 8'hCC;
    logic [6:0]  c_max_len  = 7'd64;
    logic [15:0] c_seed     = 16'hFFFF;

    // decoder state as predicted
    parse_phase_t p_phase   = SEEK_HEADER;
    logic [6:0]  p_pos      = '0;
    logic [15:0] p_type     = '0;
    logic [15:0] p_len      = '0;
    logic [15:0] p_crc      = '0;
    logic [15:0] p_crc_rx   = '0;
    logic [7:0]  p_store [PAYLOAD_DEPTH];
    logic [31:0] n_accepted = '0;
    logic [31:0] n_rejected = '0;
    logic [31:0] n_bad_crc  = '0;
    logic [31:0] n_bad_len  = '0;
    int          n_bad_end  = 0;
    int          n_bad_tail = 0;

    decode_result_t pending_results[$];

    int errors          = 0;
    int bytes_fed       = 0;
    int results_checked = 0;
    int settings_done   = 0;
    int idle_cycles     = 0;

    // sender and receiver pacing
    bit          bursty      = 0;
    int          burst_left  = 0;
    bit          sink_open   = 1;
    int          hold_seq    = 0;
    int          hold_seen   = 0;
    int          hold_left   = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    int          pattern_age = 0;

    initial
    begin
        clk = 1'b0;
    end

    always #(HALF_PERIOD) clk = ~clk;

    function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] crc,
                                                   input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[15] ^ b[i];
            r = {r[14:0], 1'b0};
            if (fb)
                r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    function automatic void push_result(input logic [2:0] ev, input logic [7:0] data,
                                        input logic [5:0] index, input logic last);
        decode_result_t r;
        r.ev    = ev;
        r.data  = data;
        r.index = index;
        r.ftype = p_type;
        r.flen  = p_len;
        r.last  = last;
        r.n_acc = n_accepted;
        r.n_rej = n_rejected;
        r.n_crc = n_bad_crc;
        r.n_len = n_bad_len;
        pending_results.push_back(r);
    endfunction

    // advance the predicted decoder by one received byte
    function automatic void decode_step(input logic [7:0] b);
        int lim;
        int n;
        case (p_phase)
            SEEK_HEADER:
            begin
                if (b == c_header)
                begin
                    p_crc = c_seed;
                    p_pos = '0;
                    p_phase = GET_TYPE;
                end
            end
            GET_TYPE:
            begin
                if (p_pos == 0)
                    p_type = {8'h00, b};
                else
                    p_type[15:8] = b;
                p_crc = crc_ccitt_byte(p_crc, b);
                p_pos = p_pos + 7'd1;
                if (p_pos >= 2)
                begin
                    p_pos = '0;
                    p_phase = GET_LENGTH;
                end
            end
            GET_LENGTH:
            begin
                if (p_pos == 0)
                    p_len = {8'h00, b};
                else
                    p_len[15:8] = b;
                p_crc = crc_ccitt_byte(p_crc, b);
                p_pos = p_pos + 7'd1;
                if (p_pos >= 2)
                begin
                    p_pos = '0;
                    lim = (c_max_len < PAYLOAD_DEPTH) ? int'(c_max_len) : PAYLOAD_DEPTH;
                    if (p_len == 0 || p_len > lim)
                    begin
                        n_bad_len = n_bad_len + 32'd1;
                        p_phase = SEEK_HEADER;
                        push_result(EV_BAD_LEN, 8'h00, 6'd0, 1'b1);
                    end
                    else
                        p_phase = GET_DATA;
                end
            end
            GET_DATA:
            begin
                p_store[p_pos[5:0]] = b;
                p_crc = crc_ccitt_byte(p_crc, b);
                p_pos = p_pos + 7'd1;
                if (p_pos >= p_len)
                begin
                    p_pos = '0;
                    p_phase = GET_ENDCODE;
                end
            end
            GET_ENDCODE:
            begin
                if (b == c_endcode)
                begin
                    p_crc = crc_ccitt_byte(p_crc, b);
                    p_pos = '0;
                    p_phase = GET_CRC;
                end
                else
                begin
                    n_bad_end++;
                    p_phase = SEEK_HEADER;
                    push_result(EV_BAD_END, 8'h00, 6'd0, 1'b1);
                end
            end
            GET_CRC:
            begin
                if (p_pos == 0)
                    p_crc_rx = {8'h00, b};
                else
                    p_crc_rx[15:8] = b;
                p_pos = p_pos + 7'd1;
                if (p_pos >= 2)
                begin
                    p_pos = '0;
                    if (p_crc == p_crc_rx)
                        p_phase = GET_TAIL;
                    else
                    begin
                        n_bad_crc = n_bad_crc + 32'd1;
                        n_rejected = n_rejected + 32'd1;
                        p_phase = SEEK_HEADER;
                        push_result(EV_BAD_CRC, 8'h00, 6'd0, 1'b1);
                    end
                end
            end
            GET_TAIL:
            begin
                p_phase = SEEK_HEADER;
                p_pos = '0;
                if (b != c_tail)
                begin
                    n_bad_tail++;
                    push_result(EV_BAD_TAIL, 8'h00, 6'd0, 1'b1);
                end
                else
                begin
                    n_accepted = n_accepted + 32'd1;
                    n = (p_len < PAYLOAD_DEPTH) ? int'(p_len) : PAYLOAD_DEPTH;
                    for (int i = 0; i < n; i++)
                        push_result(EV_ACCEPT, p_store[i], 6'(i), (i + 1 == n));
                end
            end
            default:
            begin
                p_phase = SEEK_HEADER;
                p_pos = '0;
            end
        endcase
    endfunction

    function automatic void report_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns mismatch %s: expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    function automatic void check_result();
        decode_result_t want;
        results_checked++;
        if (pending_results.size() == 0)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns unexpected result: expected none, got event %0d byte %0h",
                         $time, res_ch.event_res, res_ch.payload_byte);
            return;
        end
        want = pending_results.pop_front();
        report_field("event_res", 32'(want.ev), 32'(res_ch.event_res));
        report_field("payload_byte", 32'(want.data), 32'(res_ch.payload_byte));
        report_field("byte_index", 32'(want.index), 32'(res_ch.byte_index));
        report_field("frame_type", 32'(want.ftype), 32'(res_ch.frame_type));
        report_field("frame_length", 32'(want.flen), 32'(res_ch.frame_length));
        report_field("last", 32'(want.last), 32'(res_ch.last));
        report_field("accepted_count", want.n_acc, res_ch.accepted_count);
        report_field("rejected_count", want.n_rej, res_ch.rejected_count);
        report_field("bad_crc_count", want.n_crc, res_ch.bad_crc_count);
        report_field("len_err_count", want.n_len, res_ch.len_err_count);
    endfunction

    // check results first; a request cannot produce a result at its own edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
                check_result();
            if (rx_ch.valid && rx_ch.ready)
            begin
                bytes_fed++;
                decode_step(rx_ch.rx_byte);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("%0t ns watchdog: no request moved for %0d cycles, %0d results pending",
                         $time, idle_cycles, pending_results.size());
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // receiver: long hold when asked, else open or a rotating stall pattern
    always @(negedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end
        else if (sink_open)
            res_ch.ready <= 1'b1;
        else
        begin
            res_ch.ready <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            pattern_age++;
            if (pattern_age == 64)
            begin
                pattern_age = 0;
                if ($urandom_range(0, 3) == 0)
                    stall_pattern = 16'hFFFF;
                else
                    stall_pattern = 16'($urandom_range(0, 65535)) | 16'h0101;
            end
        end
    end

    task automatic send_item(input logic [7:0] b);
        if (bursty && burst_left == 0)
        begin
            @(negedge clk) rx_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_ch.ready);
    endtask

    // stop sending, wait for every expected result, then let the block settle
    task automatic drain_results();
        @(negedge clk) rx_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_HEADER:  c_header = value[7:0];
            CFG_ENDCODE: c_endcode = value[7:0];
            CFG_TAIL:    c_tail = value[7:0];
            CFG_MAX_LEN: c_max_len = value[6:0];
            CFG_SEED:    c_seed = value;
            default:     ;
        endcase
        @(negedge clk) cfg_we <= 1'b0;
    endtask

    task automatic apply_config(input logic [7:0] header, input logic [7:0] endcode,
                                input logic [7:0] tail, input logic [6:0] max_len,
                                input logic [15:0] seed);
        drain_results();
        write_reg(CFG_HEADER, {8'h00, header});
        write_reg(CFG_ENDCODE, {8'h00, endcode});
        write_reg(CFG_TAIL, {8'h00, tail});
        write_reg(CFG_MAX_LEN, {9'h000, max_len});
        write_reg(CFG_SEED, seed);
        settings_done++;
    endtask

    // a frame with the given fault; a faulty one ends at its bad byte or early
    task automatic send_frame(input frame_fault_t fault, input logic [15:0] ftype,
                              input logic [15:0] flen);
        logic [7:0]  body[$];
        logic [15:0] crc;
        int          n_data;
        send_item(c_header);
        if (fault == FAULT_TRUNCATED)
        begin
            repeat ($urandom_range(1, 3)) send_item(8'($urandom_range(0, 255)));
            return;
        end
        body = '{ftype[7:0], ftype[15:8], flen[7:0], flen[15:8]};
        n_data = (fault == FAULT_LENGTH) ? 0 : int'(flen);
        for (int i = 0; i < n_data; i++)
            body.push_back(8'($urandom_range(0, 255)));
        foreach (body[i])
            send_item(body[i]);
        if (fault == FAULT_LENGTH)
            return;
        if (fault == FAULT_ENDCODE)
        begin
            send_item(c_endcode ^ 8'($urandom_range(1, 255)));
            return;
        end
        body.push_back(c_endcode);
        send_item(c_endcode);
        crc = c_seed;
        foreach (body[i])
            crc = crc_ccitt_byte(crc, body[i]);
        if (fault == FAULT_CRC)
            crc = crc ^ 16'($urandom_range(1, 65535));
        send_item(crc[7:0]);
        send_item(crc[15:8]);
        if (fault == FAULT_CRC)
            return;
        if (fault == FAULT_TAIL)
            send_item(c_tail ^ 8'($urandom_range(1, 255)));
        else
            send_item(c_tail);
    endtask

    task automatic random_frame();
        int          lim;
        int          top;
        int          pick;
        logic [7:0]  noise;
        logic [15:0] ftype;
        logic [15:0] flen;
        lim = (c_max_len < PAYLOAD_DEPTH) ? int'(c_max_len) : PAYLOAD_DEPTH;
        top = (lim < 6) ? lim : 6;
        ftype = 16'($urandom_range(0, 65535));
        repeat ($urandom_range(0, 2))
        begin
            noise = 8'($urandom_range(0, 255));
            if (noise == c_header)
                noise = ~noise;
            send_item(noise);
        end
        pick = $urandom_range(0, 99);
        if (lim == 0 || pick < 8)
        begin
            flen = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(lim + 1, 65535));
            send_frame(FAULT_LENGTH, ftype, flen);
        end
        else
        begin
            flen = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, lim))
                                               : 16'($urandom_range(1, top));
            if (pick < 16)
                send_frame(FAULT_ENDCODE, ftype, flen);
            else if (pick < 24)
                send_frame(FAULT_CRC, ftype, flen);
            else if (pick < 32)
                send_frame(FAULT_TAIL, ftype, flen);
            else if (pick < 36)
                send_frame(FAULT_TRUNCATED, ftype, flen);
            else
                send_frame(FAULT_NONE, ftype, flen);
        end
    endtask

    task automatic test_directed_frames();
        bursty = 0;
        sink_open = 1;
        send_item(8'h00);
        send_item(8'hFF);
        send_frame(FAULT_NONE, 16'hFFFF, 16'd1);
        send_frame(FAULT_NONE, 16'h0000, 16'd2);
        send_frame(FAULT_LENGTH, 16'h5A5A, 16'd0);
        send_frame(FAULT_LENGTH, 16'hA5A5, 16'd65);
        send_frame(FAULT_LENGTH, 16'h1234, 16'hFFFF);
        send_frame(FAULT_ENDCODE, 16'h0001, 16'd1);
        send_frame(FAULT_CRC, 16'h8000, 16'd1);
        send_frame(FAULT_TAIL, 16'h00FF, 16'd1);
    endtask

    task automatic test_random_traffic(input bit with_idling, input int n_bytes);
        int start;
        bursty = with_idling;
        sink_open = !with_idling;
        start = bytes_fed;
        while (bytes_fed - start < n_bytes)
            random_frame();
    endtask

    task automatic test_config_sweep();
        bursty = 1;
        sink_open = 0;
        apply_config(8'h00, 8'hFF, 8'h00, 7'd1, 16'h0000);
        test_random_traffic(1, 20);
        apply_config(8'hFF, 8'h00, 8'hFF, 7'd64, 16'hFFFF);
        test_random_traffic(1, 20);
        // zero max length: every length is bad
        apply_config(8'hAA, 8'h55, 8'hCC, 7'd0, 16'h1D0F);
        send_frame(FAULT_LENGTH, 16'h1234, 16'd1);
        send_frame(FAULT_LENGTH, 16'hFEDC, 16'd64);
        apply_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 7'($urandom_range(1, 64)),
                     16'($urandom_range(0, 65535)));
        test_random_traffic(1, 20);
    endtask

    // hold the receiver while full frames keep coming, then pause until drained
    task automatic test_backpressure();
        apply_config(8'hAA, 8'h55, 8'hCC, 7'd64, 16'hFFFF);
        bursty = 0;
        sink_open = 0;
        hold_seq++;
        send_frame(FAULT_NONE, 16'hC0DE, 16'd64);
        send_frame(FAULT_NONE, 16'h0F0F, 16'd16);
        send_frame(FAULT_NONE, 16'hF0F0, 16'd8);
        drain_results();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_HEADER;
        cfg_data = '0;
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = '0;
        res_ch.ready = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        test_directed_frames();
        test_random_traffic(0, 40);
        test_config_sweep();
        test_backpressure();
        test_random_traffic(1, 40);

        drain_results();
        repeat (2 * PAYLOAD_DEPTH + 16) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            errors++;
            $display("%0t ns %0d expected results never arrived", $time,
                     pending_results.size());
        end
        $display("tb: fed %0d bytes over %0d register settings, checked %0d results",
                 bytes_fed, settings_done, results_checked);
        $display("tb: %0d frames accepted; rejects: %0d length, %0d crc, %0d endcode, %0d tail",
                 n_accepted, n_bad_len, n_bad_crc, n_bad_end, n_bad_tail);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
